[src/quadric_surface_sense_top_defines.svh]
// assertion macros shared by the quadric surface sense checker
`ifndef QUADRIC_SURFACE_SENSE_TOP_DEFINES_SVH
`define QUADRIC_SURFACE_SENSE_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define QSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define QSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/qss_pkg.sv]
// shared constants for the quadric surface sense block
`default_nettype none

package qss_pkg;

  // coordinate and coefficient width, signed Q16.16 at the default
  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned KIND_WIDTH  = 4;
  localparam int unsigned NUM_TERMS   = 4;

  // tolerance register
  localparam int unsigned        TOL_WIDTH = 40;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 40'd4295;

  // surface kind codes
  localparam logic [KIND_WIDTH-1:0] KIND_PLANE      = 4'd0;
  localparam logic [KIND_WIDTH-1:0] KIND_PLANE_X    = 4'd1;
  localparam logic [KIND_WIDTH-1:0] KIND_PLANE_Y    = 4'd2;
  localparam logic [KIND_WIDTH-1:0] KIND_PLANE_Z    = 4'd3;
  localparam logic [KIND_WIDTH-1:0] KIND_SPHERE_O   = 4'd4;
  localparam logic [KIND_WIDTH-1:0] KIND_SPHERE     = 4'd5;
  localparam logic [KIND_WIDTH-1:0] KIND_SPHERE_X   = 4'd6;
  localparam logic [KIND_WIDTH-1:0] KIND_SPHERE_Y   = 4'd7;
  localparam logic [KIND_WIDTH-1:0] KIND_SPHERE_Z   = 4'd8;
  localparam logic [KIND_WIDTH-1:0] KIND_CYLINDER_X = 4'd9;
  localparam logic [KIND_WIDTH-1:0] KIND_CYLINDER_Y = 4'd10;
  localparam logic [KIND_WIDTH-1:0] KIND_CYLINDER_Z = 4'd11;

  // sense codes
  localparam logic signed [1:0] SENSE_POS  = 2'sb01;
  localparam logic signed [1:0] SENSE_NEG  = 2'sb11;
  localparam logic signed [1:0] SENSE_ZERO = 2'sb00;

endpackage

`default_nettype wire

[src/qss_ifs.sv]
// valid/ready channel interfaces for query words and result words
`default_nettype none

interface qss_in_if #(
  parameter int unsigned W = qss_pkg::COORD_WIDTH
);
  logic                                valid;
  logic                                ready;
  logic [qss_pkg::KIND_WIDTH-1:0]      surface_kind;
  logic signed [W-1:0]                 coef_a;
  logic signed [W-1:0]                 coef_b;
  logic signed [W-1:0]                 coef_c;
  logic signed [W-1:0]                 coef_d;
  logic signed [W-1:0]                 pos_x;
  logic signed [W-1:0]                 pos_y;
  logic signed [W-1:0]                 pos_z;

  modport source (
    output valid, surface_kind, coef_a, coef_b, coef_c, coef_d, pos_x, pos_y, pos_z,
    input  ready
  );
  modport sink (
    input  valid, surface_kind, coef_a, coef_b, coef_c, coef_d, pos_x, pos_y, pos_z,
    output ready
  );
endinterface

interface qss_out_if;
  logic              valid;
  logic              ready;
  logic signed [1:0] sense;
  logic              bad_kind;

  modport source (output valid, sense, bad_kind, input ready);
  modport sink   (input  valid, sense, bad_kind, output ready);
endinterface

`default_nettype wire

[src/quadric_surface_sense_top.sv]
// quadric surface sense: side of a point against a surface with a zero band
//
// in_i carries one query word per handshake: surface kind, four Q16.16
// coefficients and a Q16.16 point. out_o returns one result word per
// query, in order: sense (+1, -1, 0 inside the band) and bad_kind for kind
// codes 12..15 (sense is then 0). cfg_we_i/cfg_wdata_i write the 40-bit
// tolerance (unsigned Q8.32 half width of the zero band); write it only while idle.
// The pipeline stages are operand select and differences, multipliers,
// pair sums, final sum and band compare. One query is accepted every cycle
// unless a stalled result waits; the five stages move together as one pipeline.
// When out_o.ready is low and a result waits, the whole pipeline holds and
// in_i.ready drops in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and loads tolerance 4295.
`default_nettype none

module quadric_surface_sense_top #(
  parameter int unsigned COORD_WIDTH = qss_pkg::COORD_WIDTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  qss_in_if.sink                              in_i,
  qss_out_if.source                           out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [qss_pkg::TOL_WIDTH-1:0]  cfg_wdata_i
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned OW = W + 1;          // operand incl. differences
  localparam int unsigned PW = 2 * OW;         // product
  localparam int unsigned SW = PW + 1;         // pair sum
  localparam int unsigned FW = PW + 2;         // surface value
  localparam int unsigned TW = qss_pkg::TOL_WIDTH;
  localparam int unsigned CW = ((FW > TW + 1) ? FW : TW + 1) + 1;
  localparam int unsigned NT = qss_pkg::NUM_TERMS;

  function automatic logic signed [OW-1:0] sext(input logic signed [W-1:0] v);
    return OW'(v);
  endfunction

  // tolerance register
  logic [TW-1:0] tol_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= qss_pkg::TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // pipeline advance: hold everything while a result waits
  logic adv;
  logic out_vld_q;
  assign adv        = !out_vld_q || out_o.ready;
  assign in_i.ready = adv;

  // valid bits
  logic v1_q, v2_q, v3_q, v4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      v1_q      <= in_i.valid;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      out_vld_q <= v4_q;
    end
  end

  // stage 1: operand selection per kind
  logic signed [OW-1:0] xe, ye, ze, ae, be, ce, de;
  logic signed [OW-1:0] dxa, dya, dza, dyb, dzc;
  logic signed [OW-1:0] p_d [NT];
  logic signed [OW-1:0] q_d [NT];
  logic [NT-1:0]        lin_d;
  logic                 bad_d;
  logic signed [OW-1:0] p_q [NT];
  logic signed [OW-1:0] q_q [NT];
  logic [NT-1:0]        lin_q;
  logic                 bad1_q;

  assign xe  = sext(in_i.pos_x);
  assign ye  = sext(in_i.pos_y);
  assign ze  = sext(in_i.pos_z);
  assign ae  = sext(in_i.coef_a);
  assign be  = sext(in_i.coef_b);
  assign ce  = sext(in_i.coef_c);
  assign de  = sext(in_i.coef_d);
  assign dxa = xe - ae;
  assign dya = ye - ae;
  assign dza = ze - ae;
  assign dyb = ye - be;
  assign dzc = ze - ce;

  always_comb begin
    for (int i = 0; i < NT; i++) begin
      p_d[i] = '0;
      q_d[i] = '0;
    end
    lin_d = '0;
    bad_d = 1'b0;
    case (in_i.surface_kind)
      qss_pkg::KIND_PLANE: begin
        p_d[0] = ae; q_d[0] = xe;
        p_d[1] = be; q_d[1] = ye;
        p_d[2] = ce; q_d[2] = ze;
        p_d[3] = de; lin_d[3] = 1'b1;
      end
      qss_pkg::KIND_PLANE_X: begin
        p_d[0] = dxa; lin_d[0] = 1'b1;
      end
      qss_pkg::KIND_PLANE_Y: begin
        p_d[0] = dya; lin_d[0] = 1'b1;
      end
      qss_pkg::KIND_PLANE_Z: begin
        p_d[0] = dza; lin_d[0] = 1'b1;
      end
      qss_pkg::KIND_SPHERE_O: begin
        p_d[0] = xe; q_d[0] = xe;
        p_d[1] = ye; q_d[1] = ye;
        p_d[2] = ze; q_d[2] = ze;
        p_d[3] = ae; q_d[3] = ae;
      end
      qss_pkg::KIND_SPHERE: begin
        p_d[0] = dxa; q_d[0] = dxa;
        p_d[1] = dyb; q_d[1] = dyb;
        p_d[2] = dzc; q_d[2] = dzc;
        p_d[3] = de;  q_d[3] = de;
      end
      qss_pkg::KIND_SPHERE_X: begin
        p_d[0] = dxa; q_d[0] = dxa;
        p_d[1] = ye;  q_d[1] = ye;
        p_d[2] = ze;  q_d[2] = ze;
        p_d[3] = be;  q_d[3] = be;
      end
      qss_pkg::KIND_SPHERE_Y: begin
        p_d[0] = xe;  q_d[0] = xe;
        p_d[1] = dya; q_d[1] = dya;
        p_d[2] = ze;  q_d[2] = ze;
        p_d[3] = be;  q_d[3] = be;
      end
      qss_pkg::KIND_SPHERE_Z: begin
        p_d[0] = xe;  q_d[0] = xe;
        p_d[1] = ye;  q_d[1] = ye;
        p_d[2] = dza; q_d[2] = dza;
        p_d[3] = be;  q_d[3] = be;
      end
      qss_pkg::KIND_CYLINDER_X: begin
        p_d[1] = ye; q_d[1] = ye;
        p_d[2] = ze; q_d[2] = ze;
        p_d[3] = ae; q_d[3] = ae;
      end
      qss_pkg::KIND_CYLINDER_Y: begin
        p_d[0] = xe; q_d[0] = xe;
        p_d[2] = ze; q_d[2] = ze;
        p_d[3] = ae; q_d[3] = ae;
      end
      qss_pkg::KIND_CYLINDER_Z: begin
        p_d[0] = xe; q_d[0] = xe;
        p_d[1] = ye; q_d[1] = ye;
        p_d[3] = ae; q_d[3] = ae;
      end
      default: begin
        bad_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q    <= p_d;
      q_q    <= q_d;
      lin_q  <= lin_d;
      bad1_q <= bad_d;
    end
  end

  // stage 2: one product or scaled linear term per lane
  logic signed [PW-1:0] term_d [NT];
  logic signed [PW-1:0] term_q [NT];
  logic                 bad2_q;

  always_comb begin
    for (int i = 0; i < NT; i++) begin
      if (lin_q[i]) begin
        term_d[i] = PW'(p_q[i]) <<< qss_pkg::FRAC_BITS;
      end else begin
        term_d[i] = p_q[i] * q_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      term_q <= term_d;
      bad2_q <= bad1_q;
    end
  end

  // stage 3: pair sums, last lane is always subtracted
  logic signed [SW-1:0] s01_q, s23_q;
  logic                 bad3_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s01_q  <= SW'(term_q[0]) + SW'(term_q[1]);
      s23_q  <= SW'(term_q[2]) - SW'(term_q[3]);
      bad3_q <= bad2_q;
    end
  end

  // stage 4: surface value
  logic signed [FW-1:0] f_q;
  logic                 bad4_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_q    <= FW'(s01_q) + FW'(s23_q);
      bad4_q <= bad3_q;
    end
  end

  // stage 5: band compare into the output register
  logic signed [CW-1:0] fe, tol_pos, tol_neg;
  logic signed [1:0]    sense_d, sense_q;
  logic                 bad_out_q;

  assign fe      = CW'(f_q);
  assign tol_pos = signed'(CW'(tol_q));
  assign tol_neg = -tol_pos;

  always_comb begin
    if (bad4_q) begin
      sense_d = qss_pkg::SENSE_ZERO;
    end else if (fe > tol_pos) begin
      sense_d = qss_pkg::SENSE_POS;
    end else if (fe < tol_neg) begin
      sense_d = qss_pkg::SENSE_NEG;
    end else begin
      sense_d = qss_pkg::SENSE_ZERO;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sense_q   <= sense_d;
      bad_out_q <= bad4_q;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.sense    = sense_q;
  assign out_o.bad_kind = bad_out_q;

endmodule

`default_nettype wire

[src/qss_checker.sv]
// port-level checker for the quadric surface sense block, with its bind
`default_nettype none

`include "quadric_surface_sense_top_defines.svh"

module qss_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic signed [1:0] sense,
  input wire logic              bad_kind
);

  // a waiting result stays offered
  `QSS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // input side opens exactly when the output register can move
  `QSS_ASSERT_IMP(a_ready_link, clk_i, rst_ni, 1'b1, in_ready == (!out_valid || out_ready), "input ready does not follow output stall")

  // unknown kind gives a zero sense
  `QSS_ASSERT_IMP(a_bad_zero, clk_i, rst_ni, out_valid && bad_kind, sense == qss_pkg::SENSE_ZERO, "bad kind with nonzero sense")

  // sense carries only the three legal codes
  `QSS_ASSERT_IMP(a_sense_code, clk_i, rst_ni, out_valid, (sense == qss_pkg::SENSE_POS) || (sense == qss_pkg::SENSE_NEG) || (sense == qss_pkg::SENSE_ZERO), "illegal sense code")

endmodule

bind quadric_surface_sense_top qss_checker u_qss_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .sense     (out_o.sense),
  .bad_kind  (out_o.bad_kind)
);

`default_nettype wire

[test/quadric_surface_sense_top_test.sv]
// self-checking testbench for the quadric surface sense block
`timescale 1ns / 100ps

module quadric_surface_sense_top_test;

  localparam int unsigned CW = qss_pkg::COORD_WIDTH;
  localparam int unsigned KW = qss_pkg::KIND_WIDTH;
  localparam int unsigned TW = qss_pkg::TOL_WIDTH;

  typedef struct {
    logic [KW-1:0]        kind;
    logic signed [CW-1:0] a, b, c, d, x, y, z;
  } query_t;

  typedef struct {
    logic signed [1:0] sense;
    logic              bad_kind;
  } verdict_t;

  // wide enough for every sum of squares at this coordinate width
  typedef logic signed [127:0] acc_t;

  localparam int          IDLE_PCT      = 6;
  localparam int          HOLD_AT       = 900;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          STALL_LIMIT   = 2000;
  localparam int          LATENCY       = 5;
  localparam int          RANDOM_PHASE  = 350;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  // first of the kind codes that name no surface
  localparam logic [KW-1:0] KIND_UNKNOWN = qss_pkg::KIND_CYLINDER_Z + 1'b1;

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  logic [TW-1:0] cfg_wdata;

  qss_in_if #(.W(CW)) query_ch ();
  qss_out_if          result_ch ();

  quadric_surface_sense_top #(.COORD_WIDTH(CW)) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (query_ch),
    .out_o       (result_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  query_t        pending_queries[$];
  verdict_t      expected_verdicts[$];
  logic [TW-1:0] band_half_width;
  bit            calm;
  bit            hold_done;
  int            hold_left;
  int unsigned   queries_accepted;
  int unsigned   mismatch_count;
  int unsigned   quiet_cycles;

  // exact side-of-surface evaluation against the zero band
  function automatic verdict_t predict_sense(query_t q, logic [TW-1:0] tol);
    acc_t     a, b, c, d, x, y, z, f, band;
    verdict_t v;
    a = q.a; b = q.b; c = q.c; d = q.d;
    x = q.x; y = q.y; z = q.z;
    band = '0;
    band[TW-1:0] = tol;
    f = '0;
    v.bad_kind = 1'b0;
    case (q.kind)
      qss_pkg::KIND_PLANE:
        f = a*x + b*y + c*z - (d <<< qss_pkg::FRAC_BITS);
      qss_pkg::KIND_PLANE_X:    f = (x - a) <<< qss_pkg::FRAC_BITS;
      qss_pkg::KIND_PLANE_Y:    f = (y - a) <<< qss_pkg::FRAC_BITS;
      qss_pkg::KIND_PLANE_Z:    f = (z - a) <<< qss_pkg::FRAC_BITS;
      qss_pkg::KIND_SPHERE_O:   f = x*x + y*y + z*z - a*a;
      qss_pkg::KIND_SPHERE:
        f = (x-a)*(x-a) + (y-b)*(y-b) + (z-c)*(z-c) - d*d;
      qss_pkg::KIND_SPHERE_X:   f = (x-a)*(x-a) + y*y + z*z - b*b;
      qss_pkg::KIND_SPHERE_Y:   f = x*x + (y-a)*(y-a) + z*z - b*b;
      qss_pkg::KIND_SPHERE_Z:   f = x*x + y*y + (z-a)*(z-a) - b*b;
      qss_pkg::KIND_CYLINDER_X: f = y*y + z*z - a*a;
      qss_pkg::KIND_CYLINDER_Y: f = x*x + z*z - a*a;
      qss_pkg::KIND_CYLINDER_Z: f = x*x + y*y - a*a;
      default:                  v.bad_kind = 1'b1;
    endcase
    if (v.bad_kind)       v.sense = qss_pkg::SENSE_ZERO;
    else if (f > band)    v.sense = qss_pkg::SENSE_POS;
    else if (f < -band)   v.sense = qss_pkg::SENSE_NEG;
    else                  v.sense = qss_pkg::SENSE_ZERO;
    return v;
  endfunction

  // signed value in [-2^k, 2^k], k up to 30
  function automatic int span(input int k);
    longint r;
    r = longint'($urandom_range(0, 32'(64'd1 << (k + 1))));
    return int'(r - (longint'(1) << k));
  endfunction

  function automatic logic signed [CW-1:0] corner_val();
    case ($urandom_range(0, 4))
      0:       return CMIN;
      1:       return CMAX;
      2:       return '0;
      3:       return 1;
      default: return -1;
    endcase
  endfunction

  // mostly points placed close to a surface so the band gets exercised
  function automatic query_t random_query();
    query_t q;
    int     pick, dl, rad, ax, i, j;
    int     cen[3];
    int     pos[3];
    longint dot;
    pick = $urandom_range(0, 99);
    q.kind = KW'($urandom_range(0, 15));
    q.a = $urandom; q.b = $urandom; q.c = $urandom; q.d = $urandom;
    q.x = $urandom; q.y = $urandom; q.z = $urandom;
    if (pick < 12) begin
      q.a = corner_val(); q.b = corner_val(); q.c = corner_val(); q.d = corner_val();
      q.x = corner_val(); q.y = corner_val(); q.z = corner_val();
    end else if (pick >= 30) begin
      q.kind = KW'($urandom_range(0, 11));
      dl = span($urandom_range(0, 20));
      if (q.kind == qss_pkg::KIND_PLANE) begin
        q.a = span(15); q.b = span(15); q.c = span(15);
        q.x = span(15); q.y = span(15); q.z = span(15);
        dot = longint'(q.a) * q.x + longint'(q.b) * q.y + longint'(q.c) * q.z;
        q.d = int'(dot >>> qss_pkg::FRAC_BITS) + dl;
      end else if (q.kind <= qss_pkg::KIND_PLANE_Z) begin
        q.a = span(30);
        case (q.kind)
          qss_pkg::KIND_PLANE_X: q.x = q.a + dl;
          qss_pkg::KIND_PLANE_Y: q.y = q.a + dl;
          default:               q.z = q.a + dl;
        endcase
      end else begin
        rad = span(24);
        cen = '{span(28), span(28), span(28)};
        ax  = $urandom_range(0, 2);
        i   = -1;
        case (q.kind)
          qss_pkg::KIND_SPHERE_O: begin
            cen = '{0, 0, 0};
            q.a = rad;
          end
          qss_pkg::KIND_SPHERE: begin
            q.a = cen[0]; q.b = cen[1]; q.c = cen[2]; q.d = rad;
          end
          qss_pkg::KIND_SPHERE_X, qss_pkg::KIND_SPHERE_Y, qss_pkg::KIND_SPHERE_Z: begin
            j = int'(q.kind - qss_pkg::KIND_SPHERE_X);
            for (int n = 0; n < 3; n++) if (n != j) cen[n] = 0;
            q.a = cen[j];
            q.b = rad;
          end
          default: begin
            // cylinder: its own axis is free, the point sits near the rim
            i   = int'(q.kind - qss_pkg::KIND_CYLINDER_X);
            cen = '{0, 0, 0};
            q.a = rad;
            ax  = (i + 1 + $urandom_range(0, 1)) % 3;
          end
        endcase
        for (int n = 0; n < 3; n++) pos[n] = cen[n] + span($urandom_range(0, 6));
        pos[ax] = cen[ax] + rad + dl;
        if (i >= 0) pos[i] = $urandom;
        q.x = pos[0]; q.y = pos[1]; q.z = pos[2];
      end
    end
    return q;
  endfunction

  task automatic add_query(input logic [KW-1:0] kind,
                           input logic signed [CW-1:0] a, b, c, d, x, y, z);
    query_t q;
    q.kind = kind;
    q.a = a; q.b = b; q.c = c; q.d = d;
    q.x = x; q.y = y; q.z = z;
    pending_queries.push_back(q);
  endtask

  // wait until every word is sent and every result is back, then let the pipe empty
  task automatic drain();
    do @(posedge clk);
    while (pending_queries.size() != 0 || query_ch.valid || expected_verdicts.size() != 0);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [TW-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    band_half_width = value;
  endtask

  task automatic add_random(input int count);
    for (int n = 0; n < count; n++) pending_queries.push_back(random_query());
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // query driver
  always @(posedge clk) begin
    query_t q;
    if (rst_n && (!query_ch.valid || query_ch.ready)) begin
      if (pending_queries.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        q = pending_queries.pop_front();
        query_ch.valid        <= 1'b1;
        query_ch.surface_kind <= q.kind;
        query_ch.coef_a       <= q.a;
        query_ch.coef_b       <= q.b;
        query_ch.coef_c       <= q.c;
        query_ch.coef_d       <= q.d;
        query_ch.pos_x        <= q.x;
        query_ch.pos_y        <= q.y;
        query_ch.pos_z        <= q.z;
      end else begin
        query_ch.valid <= 1'b0;
      end
    end
  end

  // predict the verdict of every accepted query word
  always @(posedge clk) begin
    query_t q;
    if (rst_n && query_ch.valid && query_ch.ready) begin
      q.kind = query_ch.surface_kind;
      q.a = query_ch.coef_a; q.b = query_ch.coef_b;
      q.c = query_ch.coef_c; q.d = query_ch.coef_d;
      q.x = query_ch.pos_x;  q.y = query_ch.pos_y;  q.z = query_ch.pos_z;
      expected_verdicts.push_back(predict_sense(q, band_half_width));
      queries_accepted++;
    end
  end

  // result monitor
  always @(posedge clk) begin
    verdict_t v;
    if (rst_n && result_ch.valid && result_ch.ready) begin
      if (expected_verdicts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: sense %0d bad_kind %0b",
                   result_ch.sense, result_ch.bad_kind);
      end else begin
        v = expected_verdicts.pop_front();
        if (result_ch.sense !== v.sense || result_ch.bad_kind !== v.bad_kind) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected sense %0d bad_kind %0b, %s %0d bad_kind %0b",
                     v.sense, v.bad_kind, "got sense",
                     result_ch.sense, result_ch.bad_kind);
        end
      end
    end
  end

  // receiver stalls, with one long hold-off to back up the pipe
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (!hold_done && queries_accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
      end
    end
  end

  // watchdog on stretches with no word moving on either side
  always @(posedge clk) begin
    if ((query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // reset, stimulus phases and final verdict
  initial begin
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_wdata              = '0;
    query_ch.valid         = 1'b0;
    query_ch.surface_kind  = '0;
    query_ch.coef_a        = '0;
    query_ch.coef_b        = '0;
    query_ch.coef_c        = '0;
    query_ch.coef_d        = '0;
    query_ch.pos_x         = '0;
    query_ch.pos_y         = '0;
    query_ch.pos_z         = '0;
    result_ch.ready        = 1'b0;
    band_half_width        = qss_pkg::TOL_RESET;
    calm                   = 1'b0;
    hold_done              = 1'b0;
    hold_left              = 0;
    queries_accepted       = 0;
    mismatch_count         = 0;
    quiet_cycles           = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed words at the reset tolerance
    // band edges on the general plane: exactly on the edge stays zero
    add_query(qss_pkg::KIND_PLANE, 1, 0, 0, 0, 4295, 0, 0);
    add_query(qss_pkg::KIND_PLANE, 1, 0, 0, 0, 4296, 0, 0);
    add_query(qss_pkg::KIND_PLANE, 1, 0, 0, 0, -4295, 0, 0);
    add_query(qss_pkg::KIND_PLANE, 1, 0, 0, 0, -4296, 0, 0);
    add_query(qss_pkg::KIND_PLANE, CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN);
    add_query(qss_pkg::KIND_PLANE, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, CMIN);
    // axis planes, with unused coefficients set to junk
    add_query(qss_pkg::KIND_PLANE_X, 0, -1, CMAX, CMIN, 1, CMAX, CMIN);
    add_query(qss_pkg::KIND_PLANE_X, 0, CMAX, -1, CMAX, -1, 0, 0);
    add_query(qss_pkg::KIND_PLANE_Y, 5, CMIN, CMIN, -1, CMIN, 5, CMAX);
    add_query(qss_pkg::KIND_PLANE_Z, CMAX, 0, 0, 0, 0, 0, CMIN);
    // spheres, including the widest differences
    add_query(qss_pkg::KIND_SPHERE_O, CMIN, -1, -1, -1, CMAX, CMAX, CMAX);
    add_query(qss_pkg::KIND_SPHERE, CMIN, CMAX, CMIN, 0, CMAX, CMIN, CMAX);
    add_query(qss_pkg::KIND_SPHERE, CMIN, CMAX, 7, CMAX, CMIN, CMAX, 7);
    add_query(qss_pkg::KIND_SPHERE_X, 1 << qss_pkg::FRAC_BITS, 1 << qss_pkg::FRAC_BITS,
              CMAX, CMIN, 0, 0, 0);
    add_query(qss_pkg::KIND_SPHERE_Y, 0, 0, CMIN, CMAX, 0, 3, 0);
    add_query(qss_pkg::KIND_SPHERE_Z, CMIN, CMIN, -1, -1, 0, 0, CMIN);
    // cylinders, the free axis at its extremes
    add_query(qss_pkg::KIND_CYLINDER_X, 0, CMAX, CMAX, CMAX, CMAX, 0, 0);
    add_query(qss_pkg::KIND_CYLINDER_Y, 1, 0, 0, 0, CMAX, CMIN, 0);
    add_query(qss_pkg::KIND_CYLINDER_Z, CMAX, 0, 0, 0, 1, 1, CMIN);
    // unknown kinds
    add_query(KIND_UNKNOWN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    add_query(KIND_UNKNOWN + 4'd1, 0, 0, 0, 0, 0, 0, 0);
    add_query(KIND_UNKNOWN + 4'd2, CMIN, -1, 1, 0, CMAX, CMIN, 1);
    add_query(KIND_UNKNOWN + 4'd3, -1, -1, -1, -1, -1, -1, -1);
    drain();

    // zero band, no idling on either side
    write_tolerance('0);
    calm = 1'b1;
    add_random(RANDOM_PHASE);
    drain();
    calm = 1'b0;

    // widest band
    write_tolerance('1);
    add_random(RANDOM_PHASE);
    drain();

    // random band; the long receiver hold-off falls here
    write_tolerance({8'($urandom_range(0, 255)), 32'($urandom)});
    add_random(RANDOM_PHASE);
    drain();

    // narrow band
    write_tolerance(TW'($urandom_range(0, 1 << 20)));
    add_random(RANDOM_PHASE);
    drain();

    // back to the reset value
    write_tolerance(qss_pkg::TOL_RESET);
    add_random(RANDOM_PHASE);
    drain();

    mismatch_count += expected_verdicts.size();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[quadric_surface_sense_top.f]
+incdir+src
src/qss_pkg.sv
src/qss_ifs.sv
src/quadric_surface_sense_top.sv
src/qss_checker.sv
test/quadric_surface_sense_top_test.sv
